// ===== hdl/sid_pkg.sv =====
// Shared types and constants for the 3x3 stencil image derivative block.
// No dependencies; imported by every module of the block.
package sid_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 13;
  localparam int HT_W       = 14;
  localparam int WREG_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int MAX_HEIGHT = 8192;
  localparam int WIN_N      = 9;
  localparam int JOB_DEPTH  = 4;

  localparam int DIV_W      = 56;
  localparam int SQ_W       = 17;
  localparam int RAD_W      = 18;
  localparam int ROOT_W     = 9;
  localparam int DIV_PASSES = 3;
  localparam int DIR_W      = 43;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [DIR_W-1:0] TAN_SCALE          = 43'd10000000000;
  localparam logic [DIR_W-1:0] TAN_ONE            = 43'd15574077247;
  localparam logic [DIR_W-1:0] TAN_PI_MINUS_TWO   = 43'd21850398633;
  localparam logic [DIR_W-1:0] TAN_PI_MINUS_THREE = 43'd1425465431;

  typedef enum logic [2:0] {
    MODE_IX, MODE_IY, MODE_IXY, MODE_IXX, MODE_IYY, MODE_CURV, MODE_MAG, MODE_DIR
  } sid_mode_t;

  typedef logic [WIN_N-1:0][PIX_W-1:0] sid_win_t;

  typedef enum logic {F_IDLE, F_UPD} sid_fstate_t;

  typedef enum logic [3:0] {
    B_IDLE, B_PROD1, B_PROD2, B_SUM, B_ABS, B_SQUARE, B_DIV, B_SQRT, B_DIR, B_FIN
  } sid_bstate_t;

endpackage

// ===== hdl/sid_fifo.sv =====
// Short job queue between the window front end and the arithmetic back end.
// Depends on sid_pkg for the queue depth.
module sid_fifo #(
  parameter int WIDTH = 96
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import sid_pkg::*;

  localparam int AW = $clog2(JOB_DEPTH);

  logic [WIDTH-1:0] slots [JOB_DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full    = count == (AW+1)'(JOB_DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + AW'(1);
      if (rd) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("job queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(rd && empty))
    else $error("job queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(JOB_DEPTH))
    else $error("job queue count out of range");
`endif

endmodule

// ===== hdl/sid_front.sv =====
// Front end: accepts pixel and flush requests, keeps line stores and the 3x3 window,
// and queues one edge-masked window job per owed result. Depends on sid_pkg.
module sid_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                operation,
  input  logic [sid_pkg::PIX_W-1:0]           pixel_gray,
  input  logic [$clog2(MAX_WIDTH):0]          wd,
  input  logic [sid_pkg::HT_W-1:0]            ht,
  input  logic                                size_clear,
  input  logic                                job_full,
  output logic                                job_push,
  output logic [sid_pkg::WIN_N*sid_pkg::PIX_W+$clog2(MAX_WIDTH)+sid_pkg::ROW_W:0] job_data
);
  import sid_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WD_W  = COL_W + 1;
  localparam int PND_W = COL_W + 1;

  logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];
  logic [PIX_W-1:0] up_q, mid_q;

  sid_fstate_t      state, state_next;
  logic             flush_q;
  logic [PIX_W-1:0] pix_q, pix_in;
  logic [COL_W-1:0] in_col, col_eff, oc, col_next;
  logic [ROW_W-1:0] in_row, row_eff, orow, row_next;
  logic [PND_W-1:0] pending, pending_next;
  sid_win_t         win, win_next, g;

  logic drop, start, advance, emit, last;
  logic top_bad, bot_bad, left_bad, right_bad, ok;
  logic [1:0] back;
  logic signed [ROW_W+1:0] r1, r2, htx;

  assign drop    = operation && (pending == '0);
  assign col_eff = (WD_W'(in_col) >= wd) ? '0 : in_col;
  assign row_eff = (HT_W'(in_row) >= ht) ? '0 : in_row;
  assign pix_in  = flush_q ? '0 : pix_q;
  assign emit    = flush_q || (pending >= wd + WD_W'(1));

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    full       = 1'b1;
    start      = 1'b0;
    advance    = 1'b0;
    case (state)
      F_IDLE: begin
        full = 1'b0;
        if (push && !drop) begin
          start      = 1'b1;
          state_next = F_UPD;
        end
      end
      F_UPD: begin
        if (!(emit && job_full)) begin
          advance    = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign job_push = advance && emit;

  always_ff @(posedge clk) begin
    if (start) begin
      up_q    <= mem_up[col_eff];
      mid_q   <= mem_mid[col_eff];
      flush_q <= operation;
      pix_q   <= pixel_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mem_up[in_col]  <= mid_q;
      mem_mid[in_col] <= pix_in;
    end
  end

  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = up_q;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = mid_q;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = pix_in;
  end

  always_comb begin
    if (in_col == '0) begin
      oc   = COL_W'(wd - WD_W'(1));
      back = 2'd2;
    end else begin
      oc   = in_col - COL_W'(1);
      back = 2'd1;
    end
    htx = signed'({1'b0, ht});
    r1  = signed'((ROW_W+2)'(in_row)) - signed'((ROW_W+2)'(back));
    if (r1 < 0) r1 = r1 + htx;
    r2  = r1;
    if (r2 < 0) r2 = r2 + htx;
    orow = r2[ROW_W-1:0];
  end

  assign top_bad   = orow == '0;
  assign bot_bad   = HT_W'(orow) + HT_W'(1) >= ht;
  assign left_bad  = oc == '0;
  assign right_bad = WD_W'(oc) + WD_W'(1) >= wd;
  assign last      = (WD_W'(oc) == wd - WD_W'(1)) && (HT_W'(orow) == ht - HT_W'(1));

  always_comb begin
    ok = 1'b1;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ok = !((r == 0 && top_bad) || (r == 2 && bot_bad) ||
               (k == 0 && left_bad) || (k == 2 && right_bad));
        g[r*3+k] = ok ? win_next[r*3+k] : win_next[4];
      end
    end
  end

  assign job_data = {last, orow, oc, g};

  always_comb begin
    if (flush_q)     pending_next = pending - PND_W'(1);
    else if (emit)   pending_next = wd + WD_W'(1);
    else             pending_next = pending + PND_W'(1);
    col_next = in_col + COL_W'(1);
    row_next = in_row;
    if (WD_W'(in_col) + WD_W'(1) >= wd) begin
      col_next = '0;
      row_next = (HT_W'(in_row) + HT_W'(1) >= ht) ? '0 : in_row + ROW_W'(1);
    end
    if (flush_q && pending_next == '0) begin
      col_next = '0;
      row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      pending <= '0;
      win     <= '0;
    end else if (size_clear) begin
      in_col  <= '0;
      in_row  <= '0;
      pending <= '0;
    end else if (start) begin
      in_col <= col_eff;
      in_row <= row_eff;
    end else if (advance) begin
      in_col  <= col_next;
      in_row  <= row_next;
      pending <= pending_next;
      win     <= win_next;
    end
  end

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= wd + WD_W'(1))
    else $error("owed result count beyond row length plus one");
`endif

endmodule

// ===== hdl/sid_back.sv =====
// Back end: turns one window job into a derivative value, with a bit-serial divider
// and root unit for curvature and magnitude; holds the result register. Depends on sid_pkg.
module sid_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sid_pkg::sid_mode_t         mode,
  input  logic                       job_empty,
  input  logic [sid_pkg::WIN_N*sid_pkg::PIX_W+$clog2(MAX_WIDTH)+sid_pkg::ROW_W:0] job_data,
  output logic                       job_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [sid_pkg::PIX_W-1:0]  result_value,
  output logic [$clog2(MAX_WIDTH)-1:0] out_col,
  output logic [sid_pkg::ROW_W-1:0]  out_row,
  output logic                       frame_last
);
  import sid_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WB    = WIN_N * PIX_W;

  function automatic logic signed [9:0] px(input logic [PIX_W-1:0] v);
    return signed'({2'b00, v});
  endfunction

  sid_bstate_t state, state_next;
  sid_win_t    jg;

  logic signed [8:0]  dx, dy;
  logic signed [9:0]  sxy, xx, yy;
  logic [15:0]        dx2, dy2;
  logic signed [16:0] dxdy;
  logic signed [26:0] t1, t2, t3;
  logic signed [28:0] p;
  logic [SQ_W-1:0]    sq, sq_w;
  logic [27:0]        ap;
  logic [DIV_W-1:0]   quo, quo_shift;
  logic [SQ_W-1:0]    rem;
  logic [SQ_W:0]      trial;
  logic               ge;
  logic [5:0]         step;
  logic [1:0]         pass;
  logic [RAD_W-1:0]   rad, sqr;
  logic [ROOT_W-1:0]  root, trial_r;
  logic [3:0]         rbit;
  logic               big;
  logic [DIR_W-1:0]   pa, pb1, pb2, pb3;
  logic [7:0]         adx, ady;
  logic [8:0]         asxy, axx, ayy;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic               last_q;
  logic               out_valid, fin_write;
  logic [PIX_W-1:0]   res;

  assign jg    = job_data[WB-1:0];
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    fin_write  = 1'b0;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          case (mode)
            MODE_CURV, MODE_MAG: state_next = B_PROD1;
            MODE_DIR:            state_next = B_DIR;
            default:             state_next = B_FIN;
          endcase
        end
      end
      B_PROD1:  state_next = (mode == MODE_CURV) ? B_PROD2 : B_SUM;
      B_PROD2:  state_next = B_SUM;
      B_SUM:    state_next = (mode == MODE_MAG) ? B_SQRT : B_ABS;
      B_ABS:    state_next = B_SQUARE;
      B_SQUARE: state_next = B_DIV;
      B_DIV: begin
        if (step == 6'(DIV_W-1) && pass == 2'(DIV_PASSES-1)) state_next = B_SQRT;
      end
      B_SQRT:   if (rbit == '0) state_next = B_FIN;
      B_DIR:    state_next = B_FIN;
      B_FIN: begin
        if (!out_valid || pop) begin
          fin_write  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default:  state_next = B_IDLE;
    endcase
  end

  assign sq_w      = SQ_W'(dx2) + SQ_W'(dy2) + SQ_W'(4);
  assign trial     = {rem, quo[DIV_W-1]};
  assign ge        = trial >= {1'b0, sq};
  assign quo_shift = {quo[DIV_W-2:0], ge};
  assign trial_r   = root | (ROOT_W'(1) << rbit);
  assign sqr       = RAD_W'(trial_r) * RAD_W'(trial_r);

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_pop) begin
          dx     <= 9'(px(jg[5]) - px(jg[3]));
          dy     <= 9'(px(jg[7]) - px(jg[1]));
          sxy    <= px(jg[0]) - px(jg[2]) - px(jg[6]) + px(jg[8]);
          xx     <= px(jg[3]) - (px(jg[4]) <<< 1) + px(jg[5]);
          yy     <= px(jg[1]) - (px(jg[4]) <<< 1) + px(jg[7]);
          col_q  <= job_data[WB +: COL_W];
          row_q  <= job_data[WB+COL_W +: ROW_W];
          last_q <= job_data[WB+COL_W+ROW_W];
        end
      end
      B_PROD1: begin
        dx2  <= 16'(18'(dx) * 18'(dx));
        dy2  <= 16'(18'(dy) * 18'(dy));
        dxdy <= 17'(18'(dx) * 18'(dy));
      end
      B_PROD2: begin
        t1 <= 27'(signed'({1'b0, dy2})) * 27'(xx);
        t2 <= 27'(dxdy) * 27'(sxy);
        t3 <= 27'(signed'({1'b0, dx2})) * 27'(yy);
      end
      B_SUM: begin
        p    <= (29'(t1) <<< 1) - 29'(t2) + (29'(t3) <<< 1);
        sq   <= sq_w;
        rad  <= RAD_W'(sq_w);
        root <= '0;
        rbit <= 4'(ROOT_W-1);
        big  <= 1'b0;
      end
      B_ABS:    ap <= (p < 0) ? 28'(-p) : 28'(p);
      B_SQUARE: begin
        quo  <= {28'b0, ap} * {28'b0, ap};
        rem  <= '0;
        step <= '0;
        pass <= '0;
      end
      B_DIV: begin
        quo  <= quo_shift;
        rem  <= ge ? SQ_W'(trial - {1'b0, sq}) : trial[SQ_W-1:0];
        step <= step + 6'(1);
        if (step == 6'(DIV_W-1)) begin
          step <= '0;
          rem  <= '0;
          pass <= pass + 2'(1);
          rad  <= quo_shift[RAD_W-1:0];
          big  <= quo_shift[DIV_W-1:RAD_W] != '0;
          root <= '0;
          rbit <= 4'(ROOT_W-1);
        end
      end
      B_SQRT: begin
        if (sqr <= rad) root <= trial_r;
        rbit <= rbit - 4'(1);
      end
      B_DIR: begin
        pa  <= DIR_W'(ady) * TAN_SCALE;
        pb1 <= DIR_W'(adx) * TAN_ONE;
        pb2 <= DIR_W'(adx) * TAN_PI_MINUS_TWO;
        pb3 <= DIR_W'(adx) * TAN_PI_MINUS_THREE;
      end
      default: ;
    endcase
  end

  assign adx  = 8'((dx < 0) ? -dx : dx);
  assign ady  = 8'((dy < 0) ? -dy : dy);
  assign asxy = 9'((sxy < 0) ? -sxy : sxy);
  assign axx  = 9'((xx < 0) ? -xx : xx);
  assign ayy  = 9'((yy < 0) ? -yy : yy);

  always_comb begin
    case (mode)
      MODE_IX:   res = {1'b0, adx[7:1]};
      MODE_IY:   res = {1'b0, ady[7:1]};
      MODE_IXY:  res = {1'b0, asxy[8:2]};
      MODE_IXX:  res = axx[8] ? 8'hFF : axx[7:0];
      MODE_IYY:  res = ayy[8] ? 8'hFF : ayy[7:0];
      MODE_CURV: res = (big || root[8]) ? 8'hFF : root[7:0];
      MODE_MAG:  res = root[8:1];
      MODE_DIR: begin
        if (dx > 0)       res = (pa < pb1) ? 8'd0 : 8'd1;
        else if (dx == 0) res = (dy == 0) ? 8'd0 : 8'd1;
        else if (pa <= pb3) res = 8'd3;
        else if (pa <= pb2) res = 8'd2;
        else                res = 8'd1;
      end
      default:   res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fin_write) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin_write) begin
      result_value <= res;
      out_col      <= col_q;
      out_row      <= row_q;
      frame_last   <= last_q;
    end
  end

`ifndef ASSERT_OFF
  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == B_FIN && fin_write) |=> !empty)
    else $error("finished result not presented");
`endif

endmodule

// ===== hdl/stencil_image_derivatives.sv =====
// Top level of the 3x3 stencil image derivative block: configuration registers,
// front end, job queue and back end. Depends on sid_pkg, sid_front, sid_fifo, sid_back.
//
//   channel  handshake            payload
//   input    push / full          operation, pixel_gray
//   result   empty / pop          result_value, out_col, out_row, frame_last
//   config   cfg_write            cfg_index, cfg_data
//
// The front end reads the line stores, then updates, for each request, and stalls its update
// while the job queue is full; a dropped flush needs no update. Back end: Ix..Iyy go straight
// to the result, direction adds a product state, magnitude the 9-step root, and curvature the
// bit-serial divider (three 56-step passes) and root. A 4-entry job queue sits between front
// and back; full rises while the front is busy. Reset is synchronous; line stores need no clearing.
module stencil_image_derivatives #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            operation,
  input  logic [sid_pkg::PIX_W-1:0]       pixel_gray,
  output logic                            empty,
  input  logic                            pop,
  output logic [sid_pkg::PIX_W-1:0]       result_value,
  output logic [$clog2(MAX_WIDTH)-1:0]    out_col,
  output logic [sid_pkg::ROW_W-1:0]       out_row,
  output logic                            frame_last,
  input  logic                            cfg_write,
  input  logic [sid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sid_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sid_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WD_W  = COL_W + 1;
  localparam int JOB_W = WIN_N * PIX_W + COL_W + ROW_W + 1;

  sid_mode_t         mode;
  logic [WREG_W-1:0] width_reg;
  logic [HT_W-1:0]   height_reg;
  logic [WD_W-1:0]   wd;
  logic [HT_W-1:0]   ht;
  logic              size_clear;

  logic             job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0] job_wdata, job_rdata;

  assign size_clear = cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IX;
      width_reg  <= WREG_W'(1024);
      height_reg <= HT_W'(1024);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:   mode       <= sid_mode_t'(cfg_data[2:0]);
        REG_WIDTH:  width_reg  <= cfg_data[WREG_W-1:0];
        REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_reg == '0)                 wd = WD_W'(1);
    else if (32'(width_reg) > MAX_WIDTH) wd = WD_W'(MAX_WIDTH);
    else                                 wd = WD_W'(width_reg);
    if (height_reg == '0)                      ht = HT_W'(1);
    else if (32'(height_reg) > MAX_HEIGHT)     ht = HT_W'(MAX_HEIGHT);
    else                                       ht = height_reg;
  end

  sid_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .pixel_gray (pixel_gray),
    .wd         (wd),
    .ht         (ht),
    .size_clear (size_clear),
    .job_full   (job_full),
    .job_push   (job_push),
    .job_data   (job_wdata)
  );

  sid_fifo #(.WIDTH(JOB_W)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_data (job_wdata),
    .full    (job_full),
    .rd      (job_pop),
    .rd_data (job_rdata),
    .empty   (job_empty)
  );

  sid_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .job_empty    (job_empty),
    .job_data     (job_rdata),
    .job_pop      (job_pop),
    .empty        (empty),
    .pop          (pop),
    .result_value (result_value),
    .out_col      (out_col),
    .out_row      (out_row),
    .frame_last   (frame_last)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for stencil_image_derivatives: raster frames with random content,
// checked field by field against a cycle-free predictor of the 3x3 derivative pipeline.
// Depends on sid_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sid_pkg::*;

  localparam int MAXW = 1024;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic [7:0]  value;
    logic [9:0]  col;
    logic [12:0] row;
    logic        last;
  } deriv_t;

  typedef struct {
    bit       op;
    bit [7:0] pix;
    bit       typed;
    bit [7:0] tval;
  } stim_row_t;

  logic clk = 0, rst = 1;
  logic push = 0, operation = 0, pop = 0, cfg_write = 0;
  logic [7:0] pixel_gray = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic full, empty, frame_last;
  logic [7:0] result_value;
  logic [9:0] out_col;
  logic [12:0] out_row;

  stencil_image_derivatives DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  bit [7:0] upper_line [MAXW];
  bit [7:0] middle_line [MAXW];
  bit [7:0] win [9];
  int unsigned cur_col, cur_row, owed;
  bit [2:0] cur_mode;
  int unsigned width_reg, height_reg;

  deriv_t pending_derivs [$];
  int mismatches = 0, accepted_in = 0, quiet = 0;
  bit typed_req = 0, calm = 0;
  bit [7:0] typed_val;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [7:0] clip255(longint unsigned v);
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic bit [7:0] angle_band(int dx, int dy);
    longint unsigned a = dy < 0 ? -dy : dy;
    longint unsigned b = dx < 0 ? -dx : dx;
    if (dx > 0) return (a * TAN_SCALE < b * TAN_ONE) ? 8'd0 : 8'd1;
    if (dx == 0) return dy == 0 ? 8'd0 : 8'd1;
    if (a * TAN_SCALE <= b * TAN_PI_MINUS_THREE) return 8'd3;
    if (a * TAN_SCALE <= b * TAN_PI_MINUS_TWO) return 8'd2;
    return 8'd1;
  endfunction

  function automatic bit [7:0] derivative(int g [9]);
    int dx = g[5] - g[3], dy = g[7] - g[1];
    int sxy = g[0] - g[2] - g[6] + g[8];
    int xx = g[3] - 2 * g[4] + g[5], yy = g[1] - 2 * g[4] + g[7];
    longint unsigned sq = 4 + dx * dx + dy * dy;
    longint p, ap;
    case (sid_mode_t'(cur_mode))
      MODE_IX:  return 8'((dx < 0 ? -dx : dx) / 2);
      MODE_IY:  return 8'((dy < 0 ? -dy : dy) / 2);
      MODE_IXY: return 8'((sxy < 0 ? -sxy : sxy) / 4);
      MODE_IXX: return clip255(xx < 0 ? -xx : xx);
      MODE_IYY: return clip255(yy < 0 ? -yy : yy);
      MODE_CURV: begin
        p = 2 * longint'(dy) * dy * xx - longint'(dx) * dy * sxy + 2 * longint'(dx) * dx * yy;
        ap = p < 0 ? -p : p;
        return clip255(int_sqrt(longint'(ap * ap) / (sq * sq * sq)));
      end
      MODE_MAG: return clip255(int_sqrt(sq) / 2);
      default:  return angle_band(dx, dy);
    endcase
  endfunction

  function automatic void advance_pixel(bit flush, bit [7:0] pix_in, output bit emit,
                                        output deriv_t d);
    int unsigned wd = width_reg, ht = height_reg, oc, orow, back, c;
    bit [7:0] pix = flush ? 8'd0 : pix_in;
    int g [9];
    bit ok;
    emit = 0;
    d = '0;
    if (wd < 1) wd = 1;
    if (wd > MAXW) wd = MAXW;
    if (ht < 1) ht = 1;
    if (ht > MAX_HEIGHT) ht = MAX_HEIGHT;
    if (flush && owed == 0) return;
    if (cur_col >= wd) cur_col = 0;
    if (cur_row >= ht) cur_row = 0;
    c = cur_col;
    for (int i = 0; i < 9; i += 3) begin
      win[i] = win[i + 1];
      win[i + 1] = win[i + 2];
    end
    win[2] = upper_line[c];
    win[5] = middle_line[c];
    win[8] = pix;
    upper_line[c] = middle_line[c];
    middle_line[c] = pix;
    if (flush) begin
      emit = 1;
      owed--;
    end else if (owed >= wd + 1) begin
      emit = 1;
      owed = wd + 1;
    end else begin
      owed++;
    end
    if (cur_col == 0) begin
      oc = wd - 1;
      back = 2;
    end else begin
      oc = cur_col - 1;
      back = 1;
    end
    orow = cur_row + 2 * ht - back;
    while (orow >= ht) orow -= ht;
    cur_col++;
    if (cur_col >= wd) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= ht) cur_row = 0;
    end
    if (flush && owed == 0) begin
      cur_col = 0;
      cur_row = 0;
    end
    if (!emit) return;
    for (int i = 0; i < 9; i++) begin
      ok = 1;
      if (i / 3 == 0 && orow < 1) ok = 0;
      if (i / 3 == 2 && orow + 1 >= ht) ok = 0;
      if (i % 3 == 0 && oc < 1) ok = 0;
      if (i % 3 == 2 && oc + 1 >= wd) ok = 0;
      g[i] = ok ? win[i] : win[4];
    end
    d.value = derivative(g);
    d.col = oc[9:0];
    d.row = orow[12:0];
    d.last = (oc == wd - 1 && orow == ht - 1);
  endfunction

  // predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    bit emit;
    deriv_t d, e;
    if (!rst && push && !full) begin
      advance_pixel(operation, pixel_gray, emit, d);
      if (emit) begin
        if (typed_req) d.value = typed_val;
        pending_derivs.push_back(d);
      end
    end
    if (!rst && pop && !empty) begin
      d = '{result_value, out_col, out_row, frame_last};
      if (pending_derivs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", d);
      end else begin
        e = pending_derivs.pop_front();
        if (d !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, d);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL stencil_image_derivatives");
      $finish;
    end
  end

  // result side: random stall bursts
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 16);
        pop <= 0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1;
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE: cur_mode = val[2:0];
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) width_reg = val & 14'h7FF;
        else height_reg = val & 14'h3FFF;
        cur_col = 0;
        cur_row = 0;
        owed = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
  endtask

  task automatic send(bit op, bit [7:0] pix, bit typed = 0, bit [7:0] tval = 0);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    push <= 1;
    operation <= op;
    pixel_gray <= pix;
    typed_req <= typed;
    typed_val <= tval;
    do @(posedge clk); while (full);
    @(negedge clk);
    accepted_in++;
  endtask

  task automatic settle();
    push <= 0;
    typed_req <= 0;
    while (pending_derivs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic drain();
    while (owed > 0) send(1, $urandom);
    settle();
  endtask

  task automatic setup(bit [2:0] m, int w, int h);
    write_reg(REG_MODE, m);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  stim_row_t intro [15] = '{
    '{1, 8'h00, 0, 0},
    '{0, 8'h00, 0, 0}, '{0, 8'hFF, 0, 0}, '{0, 8'h00, 0, 0},
    '{0, 8'hFF, 0, 0}, '{0, 8'hFF, 1, 127}, '{0, 8'hFF, 1, 0},
    '{0, 8'h00, 1, 127}, '{0, 8'h00, 0, 0}, '{0, 8'h00, 0, 0},
    '{1, 8'hFF, 0, 0}, '{1, 8'h00, 0, 0}, '{1, 8'hFF, 0, 0}, '{1, 8'h00, 0, 0},
    '{1, 8'h00, 0, 0}
  };

  initial begin
    int w, h, frames;
    for (int i = 0; i < MAXW; i++) begin
      upper_line[i] = 0;
      middle_line[i] = 0;
    end
    foreach (win[i]) win[i] = 0;
    cur_col = 0;
    cur_row = 0;
    owed = 0;
    cur_mode = MODE_IX;
    width_reg = 1024;
    height_reg = 1024;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // 3x3 frame of extremes in Ix mode, drained by flushes
    setup(MODE_IX, 3, 3);
    write_reg(2'd3, 14'h3FFF);
    foreach (intro[i]) send(intro[i].op, intro[i].pix, intro[i].typed, intro[i].tval);
    settle();

    // early flush, then frames back to back
    setup(MODE_IXY, 4, 3);
    repeat (6) send(0, $urandom);
    send(1, 0);
    send(1, 0);
    repeat (30) send(0, $urandom);
    drain();

    // out-of-range sizes and a wide frame
    setup(MODE_IX, 0, 0);
    repeat (5) send(0, $urandom);
    drain();
    setup(MODE_MAG, 1, 16383);
    repeat (40) send(0, $urandom);
    drain();
    setup(MODE_IX, 60, 2);
    repeat (120) send(0, $urandom);
    drain();

    // random frames
    while (accepted_in < 750) begin
      w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : $urandom_range(1, 5);
      h = $urandom_range(1, 5);
      if (accepted_in > 600) calm = 1;
      write_reg(REG_MODE, $urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
      end
      frames = $urandom_range(1, 3);
      w = width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
      h = height_reg < 1 ? 1 : height_reg;
      for (int f = 0; f < frames; f++) begin
        for (int k = 0; k < w * h; k++) begin
          if ($urandom_range(0, 40) == 0) send(1, $urandom);
          else send(0, $urandom);
        end
      end
      if ($urandom_range(0, 5) == 0) send(1, $urandom);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS stencil_image_derivatives");
    end else begin
      $display("FAIL stencil_image_derivatives");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/sid_pkg.sv
hdl/sid_fifo.sv
hdl/sid_front.sv
hdl/sid_back.sv
hdl/stencil_image_derivatives.sv
sim/testbench.sv
